>>> hdl/mdr_pkg.sv
// ----------------------------------------------------------------------------
// mdr_pkg
// Shared types and constants for the message deframe and routing block.
// ----------------------------------------------------------------------------
package mdr_pkg;

  localparam int MaxEntries      = 6;
  localparam int DefTableEntries = 6;

  localparam int IdW    = 16;
  localparam int LenW   = 16;
  localparam int ByteW  = 8;
  localparam int EntryW = 19;
  localparam int KindW  = 2;
  localparam int HdrW   = 24;

  // entry packing
  localparam int EntPrivBit  = 16;
  localparam int EntPubBit   = 17;
  localparam int EntValidBit = 18;

  // configuration port
  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;
  localparam int RegIdxW  = CfgAddrW - 2;

  localparam logic [RegIdxW-1:0] REG_SESSION_KIND = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] REG_ENTRY_BASE   = RegIdxW'(1);

  // session kinds
  localparam logic [KindW-1:0] SESS_SYSTEM = 2'd1;
  localparam logic [KindW-1:0] SESS_APP    = 2'd2;

  // header gathering: index of the last header byte
  localparam logic [1:0] HDR_LAST = 2'd3;

  typedef enum logic [2:0] {
    EV_START      = 3'd0,
    EV_BYTE       = 3'd1,
    EV_UNHANDLED  = 3'd2,
    EV_DISALLOWED = 3'd3,
    EV_DROPPED    = 3'd4,
    EV_CLEANED    = 3'd5
  } event_kind_t;

  typedef struct packed {
    logic [KindW-1:0]                   session_kind;
    logic [MaxEntries-1:0][EntryW-1:0]  entry;
  } cfg_t;

  typedef struct packed {
    logic found;
    logic allowed;
  } lookup_t;

endpackage

>>> hdl/mdr_cfg_regs.sv
// ----------------------------------------------------------------------------
// mdr_cfg_regs
// Configuration register file: session kind and the sorted endpoint table.
// ----------------------------------------------------------------------------
module mdr_cfg_regs
  import mdr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output cfg_t                cfg
);

  logic [KindW-1:0]  session_r;
  logic [EntryW-1:0] entry_r [MaxEntries];
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[CfgAddrW-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r <= '0;
      for (int i = 0; i < MaxEntries; i++) begin
        entry_r[i] <= '0;
      end
    end else if (wr_en) begin
      if (reg_idx == REG_SESSION_KIND) begin
        session_r <= pwdata[KindW-1:0];
      end
      for (int i = 0; i < MaxEntries; i++) begin
        if (reg_idx == REG_ENTRY_BASE + RegIdxW'(i)) begin
          entry_r[i] <= pwdata[EntryW-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SESSION_KIND) begin
      prdata = CfgDataW'(session_r);
    end
    for (int i = 0; i < MaxEntries; i++) begin
      if (reg_idx == REG_ENTRY_BASE + RegIdxW'(i)) begin
        prdata = CfgDataW'(entry_r[i]);
      end
    end
  end

  always_comb begin
    cfg.session_kind = session_r;
    for (int i = 0; i < MaxEntries; i++) begin
      cfg.entry[i] = entry_r[i];
    end
  end

endmodule

>>> hdl/mdr_lookup.sv
// ----------------------------------------------------------------------------
// mdr_lookup
// Sorted table search with early stop, and access check against the session.
// ----------------------------------------------------------------------------
module mdr_lookup
  import mdr_pkg::*;
#(
  parameter int TABLE_ENTRIES = DefTableEntries
)
(
  input  cfg_t           cfg,
  input  logic [IdW-1:0] ep,
  output lookup_t        res
);

  logic       searching;
  logic [1:0] grant;
  logic [1:0] access;

  always_comb begin
    grant = 2'b00;
    if (cfg.session_kind == SESS_SYSTEM) begin
      grant = 2'b01;
    end else if (cfg.session_kind == SESS_APP) begin
      grant = 2'b10;
    end
  end

  // stop at the first invalid entry or the first id above the one sought
  always_comb begin
    searching = 1'b1;
    res       = '0;
    access    = 2'b00;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (searching) begin
        if (!cfg.entry[i][EntValidBit] || (cfg.entry[i][IdW-1:0] > ep)) begin
          searching = 1'b0;
        end else if (cfg.entry[i][IdW-1:0] == ep) begin
          searching   = 1'b0;
          access      = cfg.entry[i][EntPubBit:EntPrivBit];
          res.found   = 1'b1;
          res.allowed = |(access & grant);
        end
      end
    end
  end

endmodule

>>> hdl/mdr_parser.sv
// ----------------------------------------------------------------------------
// mdr_parser
// Input register, header/payload parse state and result register.
// ----------------------------------------------------------------------------
module mdr_parser
  import mdr_pkg::*;
#(
  parameter int TABLE_ENTRIES = DefTableEntries
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_op,
  input  logic [ByteW-1:0] in_byte,
  input  logic             in_rx_ready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output event_kind_t      out_kind,
  output logic [IdW-1:0]   out_ep,
  output logic [LenW-1:0]  out_len,
  output logic [ByteW-1:0] out_byte,
  output logic             out_last
);

  // input register
  logic             in_valid_r;
  logic             in_op_r;
  logic [ByteW-1:0] in_byte_r;
  logic             in_rx_ready_r;

  // parse state
  logic [1:0]      hcnt_r,   hcnt_nxt;
  logic [HdrW-1:0] hold_r,   hold_nxt;
  logic [LenW-1:0] pay_r,    pay_nxt;
  logic [LenW-1:0] skip_r,   skip_nxt;
  logic            active_r, active_nxt;

  // result register
  logic             out_valid_r;
  event_kind_t      out_kind_r;
  logic [IdW-1:0]   out_ep_r;
  logic [LenW-1:0]  out_len_r;
  logic [ByteW-1:0] out_byte_r;
  logic             out_last_r;

  logic             advance;
  logic             has_res;
  event_kind_t      res_kind;
  logic [IdW-1:0]   res_ep;
  logic [LenW-1:0]  res_len;
  logic [ByteW-1:0] res_byte;
  logic             res_last;
  logic [LenW-1:0]  pay_dec;
  logic [IdW-1:0]   hdr_ep;
  logic [LenW-1:0]  hdr_len;
  lookup_t          look;

  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  assign hdr_len = hold_r[HdrW-1:ByteW];
  assign hdr_ep  = {hold_r[ByteW-1:0], in_byte_r};
  assign pay_dec = pay_r - LenW'(1);

  mdr_lookup #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_lookup (
    .cfg (cfg),
    .ep  (hdr_ep),
    .res (look)
  );

  always_comb begin
    hcnt_nxt   = hcnt_r;
    hold_nxt   = hold_r;
    pay_nxt    = pay_r;
    skip_nxt   = skip_r;
    active_nxt = active_r;
    has_res    = 1'b0;
    res_kind   = EV_START;
    res_ep     = '0;
    res_len    = '0;
    res_byte   = '0;
    res_last   = 1'b0;
    if (in_op_r) begin
      // cleanup: drop all parse state, report a live receiver
      hcnt_nxt   = '0;
      hold_nxt   = '0;
      pay_nxt    = '0;
      skip_nxt   = '0;
      active_nxt = 1'b0;
      has_res    = active_r;
      res_kind   = EV_CLEANED;
    end else if (skip_r != '0) begin
      skip_nxt = skip_r - LenW'(1);
    end else if (active_r) begin
      pay_nxt    = pay_dec;
      active_nxt = (pay_dec != '0);
      has_res    = 1'b1;
      res_kind   = EV_BYTE;
      res_byte   = in_byte_r;
      res_last   = (pay_dec == '0);
    end else if (hcnt_r != HDR_LAST) begin
      hold_nxt = {hold_r[HdrW-ByteW-1:0], in_byte_r};
      hcnt_nxt = hcnt_r + 2'd1;
    end else begin
      hcnt_nxt = '0;
      hold_nxt = '0;
      has_res  = 1'b1;
      res_ep   = hdr_ep;
      res_len  = hdr_len;
      if (!look.found) begin
        skip_nxt = hdr_len;
        res_kind = EV_UNHANDLED;
      end else if (!look.allowed) begin
        skip_nxt = hdr_len;
        res_kind = EV_DISALLOWED;
      end else if (!in_rx_ready_r) begin
        skip_nxt = hdr_len;
        res_kind = EV_DROPPED;
      end else if (hdr_len == '0) begin
        res_kind = EV_START;
        res_last = 1'b1;
      end else begin
        active_nxt = 1'b1;
        pay_nxt    = hdr_len;
        res_kind   = EV_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hcnt_r      <= '0;
      hold_r      <= '0;
      pay_r       <= '0;
      skip_r      <= '0;
      active_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= has_res;
        hcnt_r      <= hcnt_nxt;
        hold_r      <= hold_nxt;
        pay_r       <= pay_nxt;
        skip_r      <= skip_nxt;
        active_r    <= active_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r       <= in_op;
      in_byte_r     <= in_byte;
      in_rx_ready_r <= in_rx_ready;
    end
    if (advance && has_res) begin
      out_kind_r <= res_kind;
      out_ep_r   <= res_ep;
      out_len_r  <= res_len;
      out_byte_r <= res_byte;
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_ep     = out_ep_r;
  assign out_len    = out_len_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;

  a_skip_excl_active : assert property (@(posedge clk) disable iff (!rst_n)
    (skip_r != '0) |-> !active_r)
    else $error("skip and active receiver at once");

  a_active_has_bytes : assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (pay_r != '0))
    else $error("active receiver with no bytes left");

  a_header_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (hcnt_r != '0) |-> ((skip_r == '0) && !active_r))
    else $error("header gathering during payload");

  a_byte_emitted : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !in_op_r && (skip_r == '0) && active_r)
      |=> (out_valid_r && (out_kind_r == EV_BYTE)))
    else $error("payload word not emitted");

endmodule

>>> hdl/message_deframe_router_core.sv
// ----------------------------------------------------------------------------
// message_deframe_router_core
// Byte-stream deframer: 4-byte header, endpoint table lookup, payload routing.
// ----------------------------------------------------------------------------
// An accepted input word passes the input register, then the result register.
// Throughput: one word per cycle unless out_tready stalls (parse-state loop).
// in_tready stays high while the result register is free or being drained.
// Reset (rst_n, synchronous): clears parse state, config regs and both valids.
// ----------------------------------------------------------------------------
module message_deframe_router_core
  import mdr_pkg::*;
#(
  parameter int TABLE_ENTRIES = DefTableEntries
)
(
  input  logic                clk,
  input  logic                rst_n,
  // in_tdata: [7:0] data_byte, [8] receiver_ready, [15:9] zero
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,
  // in_tuser: [0] operation
  input  logic                in_tuser,
  // out_tdata: [15:0] endpoint_number, [31:16] message_length,
  //            [39:32] payload_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,
  // out_tuser: [2:0] event_kind
  output logic [2:0]          out_tuser,
  output logic                out_tlast,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  cfg_t             cfg;
  event_kind_t      kind;
  logic [IdW-1:0]   ep;
  logic [LenW-1:0]  len;
  logic [ByteW-1:0] pbyte;

  assign cfg_pready = 1'b1;

  mdr_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  mdr_parser #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_op       (in_tuser),
    .in_byte     (in_tdata[ByteW-1:0]),
    .in_rx_ready (in_tdata[ByteW]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_kind    (kind),
    .out_ep      (ep),
    .out_len     (len),
    .out_byte    (pbyte),
    .out_last    (out_tlast)
  );

  assign out_tdata = {pbyte, len, ep};
  assign out_tuser = kind;

endmodule
